FILE: src/pidsr_pkg.sv
// pidsr_pkg: types and constants shared by the PID speed regulator.
// No dependencies.
package pidsr_pkg;

  // one input item and one result item
  typedef struct packed {
    logic signed [31:0] encoder_count;
    logic [31:0]        time_ms;
  } pidsr_in_t;

  typedef struct packed {
    logic [7:0] drive;
    logic [1:0] status;
  } pidsr_out_t;

  localparam int DEF_COUNT_BITS = 32;
  localparam int DEF_TIME_BITS  = 32;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_RATE = 2'd3;

  localparam logic [15:0] PROP_GAIN_RST  = 16'd3277;
  localparam logic [15:0] INTEG_GAIN_RST = 16'd410;
  localparam logic [15:0] DERIV_GAIN_RST = 16'd205;

  localparam logic [1:0] STATUS_HELD     = 2'd0;
  localparam logic [1:0] STATUS_CLEARED  = 2'd1;
  localparam logic [1:0] STATUS_COMPUTED = 2'd2;

  localparam int          HOLD_MS     = 10;
  localparam int          DEADBAND_Q4 = 80;
  localparam int          INTEG_LIM   = 204800;
  localparam logic [21:0] SPEED_MAX   = 22'h0FFFFF;
  localparam logic [21:0] STEP_MAX    = 22'd409600;
  localparam logic [21:0] DERIV_MAX   = 22'd2097151;
  localparam logic [21:0] OUT_MAX     = 22'd65280;
  localparam int          SPEED_SCALE = 16000;
  localparam int          MS_PER_S    = 1000;
  localparam int          OUT_DIV     = 10;

endpackage

FILE: src/pid_speed_regulator.sv
// pid_speed_regulator: fixed-point PID speed regulator for one wheel.
// Depends on pidsr_pkg.
//
// A held or cleared item needs no arithmetic; a computed item runs seven
// passes of one shift-add multiplier and, for four of them, a restoring
// divider. One item in flight; the next is taken once the result sits in
// the output register. Synchronous reset returns to idle, drops out_valid,
// restores the default gains and clears the target and history registers.
module pid_speed_regulator #(
  parameter int COUNT_BITS = pidsr_pkg::DEF_COUNT_BITS,
  parameter int TIME_BITS  = pidsr_pkg::DEF_TIME_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  pidsr_pkg::pidsr_in_t                   in_data,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output pidsr_pkg::pidsr_out_t                  out_data,
  input  logic                                   cfg_we,
  input  logic [pidsr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pidsr_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import pidsr_pkg::*;

  localparam int NW = 56;              // smoothing numerator
  localparam int SW = 52;              // PID sum
  localparam int XW = NW - 16;
  localparam int AW = (COUNT_BITS > XW) ? COUNT_BITS : XW;
  localparam int MW = (TIME_BITS > 16) ? TIME_BITS : 16;
  localparam int PW = AW + MW;
  localparam int CW = $clog2(PW + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  localparam logic [2:0] OP_SPEED = 3'd0;
  localparam logic [2:0] OP_STEP  = 3'd1;
  localparam logic [2:0] OP_DERIV = 3'd2;
  localparam logic [2:0] OP_PT    = 3'd3;
  localparam logic [2:0] OP_IT    = 3'd4;
  localparam logic [2:0] OP_DT    = 3'd5;
  localparam logic [2:0] OP_OUT   = 3'd6;

  logic [2:0] state;
  logic [2:0] op;

  logic [15:0] prop_gain, integ_gain, deriv_gain;
  logic [13:0] target_rate;

  logic signed [21:0] prev_error;
  logic signed [19:0] integ_acc;
  logic [15:0]        smooth_out;
  logic [COUNT_BITS-1:0] prev_count, cur_count;
  logic [TIME_BITS-1:0]  prev_time, cur_time, elapsed;

  logic signed [21:0] err;
  logic signed [19:0] integ_new;
  logic signed [21:0] deriv;
  logic               diff_neg;
  logic signed [SW-1:0] sum;

  // shared multiply / divide unit
  logic [AW-1:0]        a;
  logic [MW-1:0]        m;
  logic [TIME_BITS-1:0] d;
  logic [TIME_BITS-1:0] rem;
  logic [PW-1:0]        p;
  logic [21:0]          lim;
  logic [CW-1:0]        iter;
  logic                 nodiv;

  pidsr_out_t res;

  // input extension
  logic signed [63:0]    cnt64;
  logic [63:0]           t64;
  logic [COUNT_BITS-1:0] cnt_in;
  logic [TIME_BITS-1:0]  now_in;

  assign cnt64  = 64'(in_data.encoder_count);
  assign t64    = {32'd0, in_data.time_ms};
  assign cnt_in = cnt64[COUNT_BITS-1:0];
  assign now_in = t64[TIME_BITS-1:0];

  assign in_ready = (state == S_IDLE);

  // datapath helpers
  logic [COUNT_BITS-1:0] delta, mag;
  logic [TIME_BITS:0]    rem_sh;
  logic                  rem_ge;
  logic [21:0]           q_sat;
  logic signed [21:0]    err_raw, err_c;
  logic [21:0]           err_mag;
  logic signed [22:0]    integ_w;
  logic signed [19:0]    integ_c;
  logic [19:0]           integ_mag;
  logic signed [22:0]    diff_c;
  logic [22:0]           diff_mag;
  logic signed [21:0]    deriv_c;
  logic [21:0]           deriv_mag;
  logic signed [SW-1:0]  tmag, term, sum_c;
  logic signed [NW-1:0]  sm7, num;
  logic [XW-1:0]         x;

  always_comb begin
    delta  = cur_count - prev_count;
    mag    = delta[COUNT_BITS-1] ? (~delta + 1'b1) : delta;
    rem_sh = {rem, p[PW-1]};
    rem_ge = (rem_sh >= {1'b0, d});
    q_sat  = (p > PW'(lim)) ? lim : p[21:0];

    err_raw = $signed({8'd0, target_rate}) - $signed({2'd0, q_sat[19:0]});
    if (err_raw > -22'sd80 && err_raw < 22'sd80) begin
      err_c = '0;
    end else begin
      err_c = err_raw;
    end
    err_mag = err[21] ? 22'(-err) : 22'(err);

    integ_w = {{3{integ_acc[19]}}, integ_acc}
            + (err[21] ? -$signed({1'b0, q_sat}) : $signed({1'b0, q_sat}));
    if (integ_w > 23'sd204800) begin
      integ_c = 20'sd204800;
    end else if (integ_w < -23'sd204800) begin
      integ_c = -20'sd204800;
    end else begin
      integ_c = integ_w[19:0];
    end
    integ_mag = integ_new[19] ? 20'(-integ_new) : 20'(integ_new);

    diff_c   = {err[21], err} - {prev_error[21], prev_error};
    diff_mag = diff_c[22] ? 23'(-diff_c) : 23'(diff_c);
    deriv_c  = diff_neg ? -$signed(q_sat) : $signed(q_sat);
    deriv_mag = deriv[21] ? 22'(-deriv) : 22'(deriv);

    // signed gain term from the magnitude product
    tmag = $signed(SW'(p[37:0]));
    term = '0;
    case (op)
      OP_PT:   term = (err[21] ? -tmag : tmag) <<< 8;
      OP_IT:   term = integ_new[19] ? -tmag : tmag;
      OP_DT:   term = (deriv[21] ? -tmag : tmag) <<< 8;
      default: term = '0;
    endcase
    sum_c = sum + term;

    sm7 = $signed(NW'({smooth_out, 3'd0})) - $signed(NW'(smooth_out));
    num = (sm7 <<< 16) + NW'(sum_c) + (NW'(sum_c) <<< 1);
    x   = num[NW-1:16];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      op          <= OP_SPEED;
      out_valid   <= 1'b0;
      prop_gain   <= PROP_GAIN_RST;
      integ_gain  <= INTEG_GAIN_RST;
      deriv_gain  <= DERIV_GAIN_RST;
      target_rate <= '0;
      prev_error  <= '0;
      integ_acc   <= '0;
      smooth_out  <= '0;
      prev_count  <= '0;
      prev_time   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PROP_GAIN:   prop_gain   <= cfg_data;
          CFG_INTEG_GAIN:  integ_gain  <= cfg_data;
          CFG_DERIV_GAIN:  deriv_gain  <= cfg_data;
          CFG_TARGET_RATE: target_rate <= cfg_data[13:0];
          default: ;
        endcase
      end

      // S_DONE reloads the output register itself
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur_count <= cnt_in;
            cur_time  <= now_in;
            elapsed   <= now_in - prev_time;
            state     <= S_CHECK;
          end
        end

        S_CHECK: begin
          if (elapsed < TIME_BITS'(HOLD_MS)) begin
            res   <= '{drive: smooth_out[15:8], status: STATUS_HELD};
            state <= S_DONE;
          end else if (target_rate == '0) begin
            integ_acc  <= '0;
            prev_error <= '0;
            smooth_out <= '0;
            res   <= '{drive: 8'd0, status: STATUS_CLEARED};
            state <= S_DONE;
          end else begin
            op    <= OP_SPEED;
            a     <= AW'(mag);
            m     <= MW'(SPEED_SCALE);
            d     <= elapsed;
            lim   <= SPEED_MAX;
            nodiv <= 1'b0;
            p     <= '0;
            iter  <= CW'(MW - 1);
            state <= S_MUL;
          end
        end

        S_MUL: begin
          p <= (p << 1) + (m[MW-1] ? PW'(a) : '0);
          m <= m << 1;
          if (iter == '0) begin
            rem   <= '0;
            iter  <= CW'(PW - 1);
            state <= nodiv ? S_FIN : S_DIV;
          end else begin
            iter <= iter - 1'b1;
          end
        end

        S_DIV: begin
          // restoring division, one quotient bit per cycle
          if (rem_ge) begin
            rem <= TIME_BITS'(rem_sh - {1'b0, d});
          end else begin
            rem <= rem_sh[TIME_BITS-1:0];
          end
          p <= {p[PW-2:0], rem_ge};
          if (iter == '0) begin
            state <= S_FIN;
          end else begin
            iter <= iter - 1'b1;
          end
        end

        S_FIN: begin
          p     <= '0;
          iter  <= CW'(MW - 1);
          state <= S_MUL;
          case (op)
            OP_SPEED: begin
              err   <= err_c;
              op    <= OP_STEP;
              a     <= AW'({(err_c[21] ? 22'(-err_c) : 22'(err_c)), 8'd0});
              m     <= MW'(elapsed);
              d     <= TIME_BITS'(MS_PER_S);
              lim   <= STEP_MAX;
              nodiv <= 1'b0;
            end
            OP_STEP: begin
              integ_new <= integ_c;
              diff_neg  <= diff_c[22];
              op    <= OP_DERIV;
              a     <= AW'(diff_mag);
              m     <= MW'(MS_PER_S);
              d     <= elapsed;
              lim   <= DERIV_MAX;
              nodiv <= 1'b0;
            end
            OP_DERIV: begin
              deriv <= deriv_c;
              sum   <= '0;
              op    <= OP_PT;
              a     <= AW'(err_mag);
              m     <= MW'(prop_gain);
              nodiv <= 1'b1;
            end
            OP_PT: begin
              sum   <= sum_c;
              op    <= OP_IT;
              a     <= AW'(integ_mag);
              m     <= MW'(integ_gain);
              nodiv <= 1'b1;
            end
            OP_IT: begin
              sum   <= sum_c;
              op    <= OP_DT;
              a     <= AW'(deriv_mag);
              m     <= MW'(deriv_gain);
              nodiv <= 1'b1;
            end
            OP_DT: begin
              sum <= sum_c;
              if (num <= 0) begin
                // non-positive numerator: output drops to zero
                integ_acc  <= integ_new;
                prev_error <= err;
                smooth_out <= '0;
                prev_count <= cur_count;
                prev_time  <= cur_time;
                res   <= '{drive: 8'd0, status: STATUS_COMPUTED};
                state <= S_DONE;
              end else begin
                op    <= OP_OUT;
                a     <= AW'(x);
                m     <= MW'(1);
                d     <= TIME_BITS'(OUT_DIV);
                lim   <= OUT_MAX;
                nodiv <= 1'b0;
              end
            end
            default: begin
              // OP_OUT: commit the update
              integ_acc  <= integ_new;
              prev_error <= err;
              smooth_out <= q_sat[15:0];
              prev_count <= cur_count;
              prev_time  <= cur_time;
              res   <= '{drive: q_sat[15:8], status: STATUS_COMPUTED};
              state <= S_DONE;
            end
          endcase
        end

        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_data  <= res;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: tb/sv/tb_pid_speed_regulator.sv
// tb_pid_speed_regulator: self-checking bench for the PID speed regulator.
// Depends on pidsr_pkg and pid_speed_regulator; runs directed then random items
// against a fixed-point predictor, with random idling on both handshakes.
`timescale 1ns / 1ps

module tb_pid_speed_regulator;
  import pidsr_pkg::*;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  pidsr_in_t  in_data;
  logic       out_valid;
  logic       out_ready;
  pidsr_out_t out_data;
  logic       cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pid_speed_regulator dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  localparam int SETTLE_CYCLES = 800;
  localparam int STALL_LIMIT   = 30000;

  pidsr_in_t  pending_items[$];
  pidsr_out_t drive_expected[$];
  int         fail_count = 0;
  int         tx_idle_pct = 0;
  int         rx_idle_pct = 0;
  int         stall_cycles = 0;

  // predictor copy of registers and state
  logic [15:0] kp, ki, kd;
  logic [13:0] target;
  longint      last_err, integ, smooth;
  logic [31:0] last_count, pred_time;

  // generator's running guess of count and time
  logic [31:0] gen_count, gen_time;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint scale_sat(longint unsigned a, longint unsigned m,
                                       longint unsigned d, longint unsigned lim);
    logic [127:0] p;
    p = ({64'd0, a} * {64'd0, m}) / {64'd0, d};
    return (p > lim) ? longint'(lim) : longint'(p);
  endfunction

  function automatic pidsr_out_t regulate(pidsr_in_t it);
    pidsr_out_t  r;
    logic [31:0] elapsed, delta, mag;
    longint      speed, err, stp, nxt_integ, diff, deriv, sum, num, o;
    elapsed = it.time_ms - pred_time;
    if (elapsed < HOLD_MS) begin
      r.drive  = smooth[15:8];
      r.status = STATUS_HELD;
      return r;
    end
    if (target == 0) begin
      integ = 0; last_err = 0; smooth = 0;
      r.drive  = 8'd0;
      r.status = STATUS_CLEARED;
      return r;
    end
    delta = it.encoder_count - last_count;
    mag   = delta[31] ? -delta : delta;
    speed = scale_sat(mag, SPEED_SCALE, elapsed, SPEED_MAX);
    err   = longint'(target) - speed;
    if (err > -DEADBAND_Q4 && err < DEADBAND_Q4) err = 0;
    stp = scale_sat((err < 0 ? -err : err) * 256, elapsed, MS_PER_S, 2 * INTEG_LIM);
    nxt_integ = integ + (err < 0 ? -stp : stp);
    if (nxt_integ > INTEG_LIM) nxt_integ = INTEG_LIM;
    if (nxt_integ < -INTEG_LIM) nxt_integ = -INTEG_LIM;
    diff  = err - last_err;
    deriv = scale_sat(diff < 0 ? -diff : diff, MS_PER_S, elapsed, DERIV_MAX);
    if (diff < 0) deriv = -deriv;
    sum = longint'(kp) * err * 256 + longint'(ki) * nxt_integ
        + longint'(kd) * deriv * 256;
    num = 7 * smooth * 65536 + 3 * sum;
    o = (num <= 0) ? 0 : num / 655360;
    if (o > OUT_MAX) o = OUT_MAX;
    integ = nxt_integ; last_err = err; smooth = o;
    last_count = it.encoder_count; pred_time = it.time_ms;
    r.drive  = o[15:8];
    r.status = STATUS_COMPUTED;
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      if (in_valid && in_ready) drive_expected.push_back(regulate(in_data));
      if (!in_valid || in_ready) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
          in_data  <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    pidsr_out_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (drive_expected.size() == 0) begin
          $error("unexpected result: drive %0d status %0d", out_data.drive, out_data.status);
          fail_count++;
        end else begin
          want = drive_expected.pop_front();
          if (out_data.drive !== want.drive) begin
            $error("drive: expected %0d, got %0d", want.drive, out_data.drive);
            fail_count++;
          end
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            fail_count++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (pending_items.size() == 0 && drive_expected.size() == 0 && !in_valid)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_PROP_GAIN:  kp = val;
      CFG_INTEG_GAIN: ki = val;
      CFG_DERIV_GAIN: kd = val;
      default:        target = val[13:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(logic [15:0] p, logic [15:0] i, logic [15:0] d, logic [15:0] t);
    write_reg(CFG_PROP_GAIN, p);
    write_reg(CFG_INTEG_GAIN, i);
    write_reg(CFG_DERIV_GAIN, d);
    write_reg(CFG_TARGET_RATE, t);
  endtask

  // hold off until every expected result is back, then let the block settle
  task automatic drain();
    while (pending_items.size() > 0 || drive_expected.size() > 0 || in_valid)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic add_item(logic [31:0] cnt, logic [31:0] t);
    pidsr_in_t it;
    it.encoder_count = cnt;
    it.time_ms       = t;
    pending_items.push_back(it);
    gen_count = cnt;
    gen_time  = t;
  endtask

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(5))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(8191));
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  task automatic random_items(int n);
    int dt, ideal, noise;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(9) == 0) begin
        add_item($urandom, $urandom);
      end else begin
        dt = ($urandom_range(7) == 0) ? $urandom_range(9) : $urandom_range(10, 400);
        ideal = (int'(target) * dt) / 16000;
        case ($urandom_range(3))
          0:       noise = 0;
          1:       noise = $urandom_range(4) - 2;
          2:       noise = $urandom_range(60) - 30;
          default: noise = $urandom_range(2000) - 1000;
        endcase
        if ($urandom_range(1)) ideal = -ideal;
        add_item(gen_count + ideal + noise, gen_time + dt);
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    kp = PROP_GAIN_RST; ki = INTEG_GAIN_RST; kd = DERIV_GAIN_RST; target = '0;
    last_err = 0; integ = 0; smooth = 0; last_count = '0; pred_time = '0;
    gen_count = '0; gen_time = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // target zero after reset: too soon, clear, and clear at the largest elapsed
    add_item(32'd0, 32'd5);
    add_item(32'hFFFFFFFF, 32'd100);
    add_item(32'h80000000, 32'hFFFFFFFF);
    drain();

    // full gains around an exact match, deadband, wraps and saturation
    set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd16000);
    add_item(32'd0, 32'd1000);
    add_item(32'd1000, 32'd2000);
    add_item(32'd2002, 32'd3000);
    add_item(32'd3012, 32'd4000);
    add_item(32'd3012, 32'd4005);
    add_item(32'h7FFFFFFF, 32'd4020);
    add_item(32'h80000000, 32'd4040);
    add_item(32'h00000000, 32'd4060);
    add_item(32'h00000100, 32'd4060 + 32'hFFFFF000);
    add_item(32'h00000200, 32'd500);
    add_item(32'h00000200, 32'hFFFFFFFF);
    drain();

    set_regs(16'd0, 16'd0, 16'd0, 16'd1);
    add_item(32'd5, 32'd600);
    add_item(32'd5, 32'd700);
    drain();

    set_regs(16'hFFFF, 16'd0, 16'd0, 16'hFFFF);
    random_items(30);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      tx_idle_pct = (ph < 2) ? 30 : (ph < 4) ? 62 : 0;
      rx_idle_pct = (ph < 2) ? 62 : (ph < 4) ? 30 : 0;
      set_regs(pick_gain(), pick_gain(), pick_gain(),
               (ph == 3) ? 16'd0 : (ph == 5) ? 16'd16383 : 16'($urandom_range(16383)));
      random_items(68);
      drain();
    end

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/pidsr_pkg.sv
src/pid_speed_regulator.sv
tb/sv/tb_pid_speed_regulator.sv
